/* rtl/core/progressive_ac_coefficient_split_core_defines.svh */
// Assertion macros shared by the core. Each macro wraps one clocked concurrent
// assertion with reset disable, and collapses to nothing when NO_ASSERTIONS is set.
`ifndef PROGRESSIVE_AC_COEFFICIENT_SPLIT_CORE_DEFINES_SVH
`define PROGRESSIVE_AC_COEFFICIENT_SPLIT_CORE_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Property must hold at every clock edge outside reset.
`define PACS_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Expression must never be true outside reset.
`define PACS_ASSERT_NEVER(lbl, clk, rst_n, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);
`else
`define PACS_ASSERT(lbl, clk, rst_n, prop, msg)
`define PACS_ASSERT_NEVER(lbl, clk, rst_n, expr, msg)
`endif

`endif

/* rtl/core/pacs_pkg.sv */
`timescale 1ns / 1ps

package pacs_pkg;

	localparam int MAX_PASSES = 11;
	localparam int BLOCK_DIM  = 8;
	localparam int COEFF_BITS = 32;

	localparam int PASS_W  = 4;
	localparam int NIB_W   = 4;
	localparam int CFG_W   = MAX_PASSES * NIB_W;
	localparam int PADDR_W = 5;
	localparam int PDATA_W = 64;

	// Register indexes, taken from paddr[4:3] (registers sit at 8-byte spacing).
	localparam logic [1:0] REG_PASS_COUNT   = 2'd0;
	localparam logic [1:0] REG_PASS_SHIFTS  = 2'd1;
	localparam logic [1:0] REG_COEFF_COUNTS = 2'd2;

	// Reset values of the registers.
	localparam logic [PASS_W-1:0] PASS_COUNT_RST   = 4'd1;
	localparam logic [CFG_W-1:0]  PASS_SHIFTS_RST  = '0;
	localparam logic [CFG_W-1:0]  COEFF_COUNTS_RST = 44'h888_8888_8888;

	typedef struct packed {
		logic signed [COEFF_BITS-1:0] coeff_value;
		logic [7:0]                   col;
		logic [7:0]                   row;
		logic [5:0]                   blocks_wide;
		logic [5:0]                   blocks_high;
	} coeff_item_t;

	typedef struct packed {
		logic [PASS_W-1:0]            pass_index;
		logic signed [COEFF_BITS-1:0] coeff_out;
		logic                         last;
	} pass_item_t;

	// Decoded configuration as seen by the datapath.
	typedef struct packed {
		logic [PASS_W-1:0]                     pass_total;
		logic [MAX_PASSES-1:0][NIB_W-1:0]      shifts;
		logic [MAX_PASSES-1:0][NIB_W-1:0]      counts;
	} cfg_t;

	// Per-pass sequencing state carried between passes of one item.
	typedef struct packed {
		logic [PASS_W-1:0] pass_k;
		logic [NIB_W-1:0]  done_side;
		logic [NIB_W-1:0]  prev_shift;
	} pass_ctx_t;

	// Result of one pass plus the sequencing state for the following pass.
	typedef struct packed {
		logic signed [COEFF_BITS-1:0] coeff;
		logic                         is_last;
		logic [NIB_W-1:0]             next_done;
		logic [NIB_W-1:0]             next_prev_shift;
	} pass_res_t;

endpackage

/* rtl/core/pacs_cfg_regs.sv */
`timescale 1ns / 1ps

module pacs_cfg_regs import pacs_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready,
	output cfg_t               cfg
);

	logic [PASS_W-1:0] pass_count_q;
	logic [CFG_W-1:0]  pass_shifts_q;
	logic [CFG_W-1:0]  coeff_counts_q;
	logic [1:0]        reg_idx;
	logic              wr_en;

	assign pready  = 1'b1;
	assign reg_idx = paddr[PADDR_W-1:3];
	assign wr_en   = psel & penable & pwrite;

	// Register writes complete in the access phase of a write transaction.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pass_count_q   <= PASS_COUNT_RST;
			pass_shifts_q  <= PASS_SHIFTS_RST;
			coeff_counts_q <= COEFF_COUNTS_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_PASS_COUNT:   pass_count_q   <= pwdata[PASS_W-1:0];
				REG_PASS_SHIFTS:  pass_shifts_q  <= pwdata[CFG_W-1:0];
				REG_COEFF_COUNTS: coeff_counts_q <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	// Read back.
	always_comb begin
		case (reg_idx)
			REG_PASS_COUNT:   prdata = {{(PDATA_W-PASS_W){1'b0}}, pass_count_q};
			REG_PASS_SHIFTS:  prdata = {{(PDATA_W-CFG_W){1'b0}}, pass_shifts_q};
			REG_COEFF_COUNTS: prdata = {{(PDATA_W-CFG_W){1'b0}}, coeff_counts_q};
			default:          prdata = '0;
		endcase
	end

	// A pass count of zero means one pass; counts above the maximum saturate.
	always_comb begin
		if (pass_count_q == '0) begin
			cfg.pass_total = PASS_W'(1);
		end else if (pass_count_q > PASS_W'(MAX_PASSES)) begin
			cfg.pass_total = PASS_W'(MAX_PASSES);
		end else begin
			cfg.pass_total = pass_count_q;
		end
		cfg.shifts = pass_shifts_q;
		cfg.counts = coeff_counts_q;
	end

endmodule

/* rtl/core/pacs_pass_calc.sv */
`timescale 1ns / 1ps

module pacs_pass_calc import pacs_pkg::*; (
	input  coeff_item_t item,
	input  pass_ctx_t   ctx,
	input  cfg_t        cfg,
	output pass_res_t   res
);

	logic [NIB_W-1:0]             shift;
	logic [NIB_W-1:0]             cnt_raw;
	logic [NIB_W-1:0]             cnt;
	logic [9:0]                   frame_w;
	logic [9:0]                   frame_h;
	logic [9:0]                   done_w;
	logic [9:0]                   done_h;
	logic                         in_frame;
	logic                         in_done;
	logic [COEFF_BITS-1:0]        rem_mask;
	logic [COEFF_BITS-1:0]        rem_low;
	logic signed [COEFF_BITS-1:0] rem_val;
	logic [COEFF_BITS-1:0]        bias;
	logic signed [COEFF_BITS-1:0] biased;

	assign shift   = cfg.shifts[ctx.pass_k];
	assign cnt_raw = cfg.counts[ctx.pass_k];
	assign cnt     = (cnt_raw > NIB_W'(BLOCK_DIM)) ? NIB_W'(BLOCK_DIM) : cnt_raw;

	// Frame square of this pass and the square already finished earlier.
	assign frame_w  = 10'(item.blocks_wide) * 10'(cnt);
	assign frame_h  = 10'(item.blocks_high) * 10'(cnt);
	assign done_w   = 10'(item.blocks_wide) * 10'(ctx.done_side);
	assign done_h   = 10'(item.blocks_high) * 10'(ctx.done_side);
	assign in_frame = (10'(item.col) < frame_w) && (10'(item.row) < frame_h);
	assign in_done  = (10'(item.col) < done_w) && (10'(item.row) < done_h);

	// Remainder by the previous pass's power of two, sign following the value.
	assign rem_mask = (COEFF_BITS'(1) << ctx.prev_shift) - COEFF_BITS'(1);
	assign rem_low  = item.coeff_value & rem_mask;
	always_comb begin
		if (ctx.prev_shift == '0) begin
			rem_val = item.coeff_value;
		end else if (item.coeff_value[COEFF_BITS-1] && (rem_low != '0)) begin
			rem_val = rem_low | ~rem_mask;
		end else begin
			rem_val = rem_low;
		end
	end

	// Shift right rounding toward zero: bias negative values before the shift.
	assign bias   = rem_val[COEFF_BITS-1] ?
		((COEFF_BITS'(1) << shift) - COEFF_BITS'(1)) : '0;
	assign biased = rem_val + $signed(bias);

	always_comb begin
		if (cfg.pass_total == PASS_W'(1)) begin
			res.coeff = item.coeff_value;
		end else if (in_frame && !in_done) begin
			res.coeff = biased >>> shift;
		end else begin
			res.coeff = '0;
		end
		res.is_last         = (ctx.pass_k == (cfg.pass_total - PASS_W'(1)));
		res.next_done       = (shift == '0) ? cnt : ctx.done_side;
		res.next_prev_shift = shift;
	end

endmodule

/* rtl/core/progressive_ac_coefficient_split_core.sv */
`timescale 1ns / 1ps
// Splits each coefficient transaction into one result per configured progressive
// pass, in pass order, with last set on the final pass. An item has pass_count
// passes (1 to 11, zero counts as one): the input register holds it while one
// pass calculator produces one pass per cycle into the output register, unless
// pass_stall holds that register full. The next item is accepted in the cycle
// its predecessor's final pass moves to the output register, so results stream
// with no gap. Configuration must be written only while idle.
`include "progressive_ac_coefficient_split_core_defines.svh"

module progressive_ac_coefficient_split_core import pacs_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               coeff_valid,
	output logic               coeff_stall,
	input  coeff_item_t        coeff_item,
	output logic               pass_valid,
	input  logic               pass_stall,
	output pass_item_t         pass_item,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic               pready
);

	cfg_t        cfg;
	coeff_item_t item_s1;
	logic        valid_s1;
	pass_ctx_t   ctx_q;
	pass_res_t   res;
	pass_item_t  out_s2;
	logic        out_valid_s2;
	logic        advance;
	logic        in_acc;
	logic        out_acc;

	pacs_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	pacs_pass_calc u_calc (
		.item (item_s1),
		.ctx  (ctx_q),
		.cfg  (cfg),
		.res  (res)
	);

	// A pass moves forward when the output register is empty or being drained.
	assign advance     = valid_s1 & (~out_valid_s2 | ~pass_stall);
	assign coeff_stall = valid_s1 & ~(advance & res.is_last);
	assign in_acc      = coeff_valid & ~coeff_stall;
	assign out_acc     = out_valid_s2 & ~pass_stall;

	// Input register and pass sequencing state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			ctx_q    <= '0;
		end else if (in_acc) begin
			valid_s1         <= 1'b1;
			ctx_q.pass_k     <= '0;
			ctx_q.done_side  <= NIB_W'(1);
			ctx_q.prev_shift <= '0;
		end else if (advance) begin
			valid_s1         <= ~res.is_last;
			ctx_q.pass_k     <= ctx_q.pass_k + PASS_W'(1);
			ctx_q.done_side  <= res.next_done;
			ctx_q.prev_shift <= res.next_prev_shift;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			item_s1 <= coeff_item;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (advance) begin
			out_valid_s2 <= 1'b1;
		end else if (out_acc) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			out_s2.pass_index <= ctx_q.pass_k;
			out_s2.coeff_out  <= res.coeff;
			out_s2.last       <= res.is_last;
		end
	end

	assign pass_valid = out_valid_s2;
	assign pass_item  = out_s2;

	// A non-final pass is followed at once by the next pass of the same item.
	`PACS_ASSERT(a_pass_follows, clk, arst_n, out_acc && !out_s2.last |=> out_valid_s2 && (out_s2.pass_index == $past(out_s2.pass_index) + PASS_W'(1)), "pass sequence broken")
	// After a final pass, any result shown starts a new item at pass zero.
	`PACS_ASSERT(a_item_restart, clk, arst_n, out_acc && out_s2.last |=> !out_valid_s2 || (out_s2.pass_index == '0), "new item does not start at pass zero")
	// The last flag marks exactly the final configured pass.
	`PACS_ASSERT_NEVER(a_last_mismatch, clk, arst_n, out_valid_s2 && (out_s2.last != (out_s2.pass_index == cfg.pass_total - PASS_W'(1))), "last flag disagrees with pass count")

endmodule
